### design/swm_pkg.sv
// ----------------------------------------------------------------------------
// swm_pkg
// Shared types for the sliding window maximum: controller states and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package swm_pkg;

    localparam int CFG_W = 7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DROP_RD,
        ST_DROP_CK,
        ST_POP_RD,
        ST_POP_CK,
        ST_PUSH,
        ST_FRONT_RD,
        ST_EMIT
    } swm_state_t;

    typedef struct packed {
        logic take;
        logic rd_head;
        logic rd_back;
        logic drop;
        logic pop;
        logic push;
        logic load_out;
    } swm_cmd_t;

    typedef struct packed {
        logic cnt_zero;
        logic drop_hit;
        logic pop_hit;
        logic warm_ready;
        logic out_free;
    } swm_sts_t;

endpackage

### design/swm_ram.sv
// ----------------------------------------------------------------------------
// swm_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module swm_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### design/swm_ctrl.sv
// ----------------------------------------------------------------------------
// swm_ctrl
// Controller: sequences drop, pop, push and result steps for each sample.
// ----------------------------------------------------------------------------
module swm_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  swm_pkg::swm_sts_t sts,
    output swm_pkg::swm_cmd_t cmd
);

    import swm_pkg::*;

    swm_state_t state_reg;
    swm_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DROP_RD;
                end
            end
            ST_DROP_RD:  state_next = sts.cnt_zero ? ST_PUSH : ST_DROP_CK;
            ST_DROP_CK:  state_next = sts.drop_hit ? ST_DROP_RD : ST_POP_RD;
            ST_POP_RD:   state_next = sts.cnt_zero ? ST_PUSH : ST_POP_CK;
            ST_POP_CK:   state_next = sts.pop_hit ? ST_POP_RD : ST_PUSH;
            ST_PUSH:     state_next = ST_FRONT_RD;
            ST_FRONT_RD: state_next = sts.warm_ready ? ST_EMIT : ST_IDLE;
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.take = in_valid;
            end
            ST_DROP_RD:  cmd.rd_head  = !sts.cnt_zero;
            ST_DROP_CK:  cmd.drop     = sts.drop_hit;
            ST_POP_RD:   cmd.rd_back  = !sts.cnt_zero;
            ST_POP_CK:   cmd.pop      = sts.pop_hit;
            ST_PUSH:     cmd.push     = 1'b1;
            ST_FRONT_RD: cmd.rd_head  = sts.warm_ready;
            ST_EMIT:     cmd.load_out = sts.out_free;
            default:     cmd          = '0;
        endcase
    end

endmodule

### design/swm_datapath.sv
// ----------------------------------------------------------------------------
// swm_datapath
// Datapath: deque pointers, position and warm-up counters, candidate RAM,
// window register and output register.
// ----------------------------------------------------------------------------
module swm_datapath #(
    parameter int WINDOW_MAX   = 64,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [swm_pkg::CFG_W-1:0] cfg_data,
    input  logic [SAMPLE_WIDTH-1:0]   in_sample,
    input  logic                      in_start,
    input  swm_pkg::swm_cmd_t         cmd,
    output swm_pkg::swm_sts_t         sts,
    input  logic                      out_ready,
    output logic                      out_valid,
    output logic [SAMPLE_WIDTH-1:0]   out_sample
);

    import swm_pkg::*;

    localparam int ADDR_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CNT_W   = $clog2(WINDOW_MAX + 1);
    localparam int POS_W   = $clog2(2 * WINDOW_MAX);
    localparam int WCMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int ENTRY_W = SAMPLE_WIDTH + POS_W;

    logic [SAMPLE_WIDTH-1:0] sample_reg;
    logic [ADDR_W-1:0]       head_reg, head_next;
    logic [ADDR_W-1:0]       tail_reg, tail_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [POS_W-1:0]        pos_reg, pos_next;
    logic [CNT_W-1:0]        warm_reg, warm_next;
    logic [CFG_W-1:0]        window_size_reg;
    logic                    out_valid_reg;
    logic [SAMPLE_WIDTH-1:0] out_data_reg;

    logic [ADDR_W-1:0]       head_inc, tail_inc, tail_dec;
    logic [WCMP_W-1:0]       win_ext;
    logic [CNT_W-1:0]        win_eff;
    logic [ENTRY_W-1:0]      rd_entry;
    logic [SAMPLE_WIDTH-1:0] rd_value;
    logic [POS_W-1:0]        rd_pos;
    logic [POS_W:0]          age_wrap;
    logic [POS_W-1:0]        age;
    logic                    cnt_full;

    assign head_inc = (head_reg == ADDR_W'(WINDOW_MAX - 1)) ? '0 : head_reg + 1'b1;
    assign tail_inc = (tail_reg == ADDR_W'(WINDOW_MAX - 1)) ? '0 : tail_reg + 1'b1;
    assign tail_dec = (tail_reg == '0) ? ADDR_W'(WINDOW_MAX - 1) : tail_reg - 1'b1;
    assign cnt_full = (count_reg == CNT_W'(WINDOW_MAX));

    // clamp the window to 1..WINDOW_MAX
    assign win_ext = WCMP_W'(window_size_reg);
    always_comb
    begin
        if (window_size_reg == '0)
        begin
            win_eff = CNT_W'(1);
        end
        else if (win_ext > WCMP_W'(WINDOW_MAX))
        begin
            win_eff = CNT_W'(WINDOW_MAX);
        end
        else
        begin
            win_eff = CNT_W'(win_ext);
        end
    end

    swm_ram #(
        .WIDTH  (ENTRY_W),
        .DEPTH  (WINDOW_MAX),
        .ADDR_W (ADDR_W)
    ) u_cand_ram (
        .clk     (clk),
        .wr_en   (cmd.push),
        .wr_addr (tail_reg),
        .wr_data ({pos_reg, sample_reg}),
        .rd_en   (cmd.rd_head | cmd.rd_back),
        .rd_addr (cmd.rd_back ? tail_dec : head_reg),
        .rd_data (rd_entry)
    );

    assign rd_value = rd_entry[SAMPLE_WIDTH-1:0];
    assign rd_pos   = rd_entry[ENTRY_W-1:SAMPLE_WIDTH];

    // age modulo 2*WINDOW_MAX
    assign age_wrap = {1'b0, pos_reg} + (POS_W + 1)'(2 * WINDOW_MAX) - {1'b0, rd_pos};
    assign age      = (pos_reg >= rd_pos) ? (pos_reg - rd_pos) : age_wrap[POS_W-1:0];

    assign sts.cnt_zero   = (count_reg == '0);
    assign sts.drop_hit   = (age >= POS_W'(win_eff));
    assign sts.pop_hit    = ($signed(rd_value) < $signed(sample_reg));
    assign sts.warm_ready = (warm_reg >= win_eff);
    assign sts.out_free   = !out_valid_reg || out_ready;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        pos_next   = pos_reg;
        warm_next  = warm_reg;
        if (cmd.take && in_start)
        begin
            head_next  = '0;
            tail_next  = '0;
            count_next = '0;
            pos_next   = '0;
            warm_next  = '0;
        end
        if (cmd.drop)
        begin
            head_next  = head_inc;
            count_next = count_reg - 1'b1;
        end
        if (cmd.pop)
        begin
            tail_next  = tail_dec;
            count_next = count_reg - 1'b1;
        end
        if (cmd.push)
        begin
            tail_next = tail_inc;
            if (cnt_full)
            begin
                head_next = head_inc;
            end
            else
            begin
                count_next = count_reg + 1'b1;
            end
            pos_next = (pos_reg == POS_W'(2 * WINDOW_MAX - 1)) ? '0 : pos_reg + 1'b1;
            if (warm_reg != CNT_W'(WINDOW_MAX))
            begin
                warm_next = warm_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg        <= '0;
            tail_reg        <= '0;
            count_reg       <= '0;
            pos_reg         <= '0;
            warm_reg        <= '0;
            window_size_reg <= CFG_W'(1);
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            pos_reg   <= pos_next;
            warm_reg  <= warm_next;
            if (cfg_we)
            begin
                window_size_reg <= cfg_data;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            sample_reg <= in_sample;
        end
        if (cmd.load_out)
        begin
            out_data_reg <= rd_value;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_sample = out_data_reg;

endmodule

### design/sliding_window_maximum.sv
// ----------------------------------------------------------------------------
// sliding_window_maximum
// Running maximum over the last window_size signed samples, kept in a
// monotonic deque of (value, position) candidates in a RAM.
//
//   channel   direction  payload
//   s_axis    in         tdata: sample, tuser: stream_start
//   m_axis    out        tdata: window_max
//   cfg       in         data: window_size
//
// Per sample: the transfer, a drop scan and a pop scan that each read and test
// deque entries one at a time through the single RAM read port, a push, a
// front read and a result load when due. A new sample is taken only once the
// steps for the last one are done.
// Reset clears the deque and counters and sets window_size to 1. A stalled
// result holds; the next sample is taken, and its result load waits for m_axis.
// ----------------------------------------------------------------------------
module sliding_window_maximum #(
    parameter int WINDOW_MAX   = 64,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [((SAMPLE_WIDTH + 7) / 8) * 8-1:0] s_axis_tdata,  // sample
    input  logic                                  s_axis_tuser,  // stream_start
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [((SAMPLE_WIDTH + 7) / 8) * 8-1:0] m_axis_tdata,  // window_max
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [swm_pkg::CFG_W-1:0]             cfg_data
);

    import swm_pkg::*;

    localparam int DATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;

    swm_cmd_t                cmd;
    swm_sts_t                sts;
    logic [SAMPLE_WIDTH-1:0] result;

    assign cfg_ready = 1'b1;

    swm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    swm_datapath #(
        .WINDOW_MAX   (WINDOW_MAX),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_valid & cfg_ready),
        .cfg_data   (cfg_data),
        .in_sample  (s_axis_tdata[SAMPLE_WIDTH-1:0]),
        .in_start   (s_axis_tuser),
        .cmd        (cmd),
        .sts        (sts),
        .out_ready  (m_axis_tready),
        .out_valid  (m_axis_tvalid),
        .out_sample (result)
    );

    assign m_axis_tdata = DATA_W'(result);

`ifndef SYNTHESIS
    a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result loaded over an untaken transfer");

    a_one_deque_op: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.take, cmd.drop, cmd.pop, cmd.push, cmd.load_out}))
        else $error("conflicting deque commands");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input ready while a sample is in work");

    a_load_shows_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> m_axis_tvalid)
        else $error("loaded result not presented");
`endif

endmodule

### dv/tb_sliding_window_maximum.sv
// ----------------------------------------------------------------------------
// tb_sliding_window_maximum
// Stream-level test of the sliding window maximum. An array-based deque model
// predicts every window_max from the samples as they transfer in. A checker
// compares each output transfer with the oldest prediction. Directed tests
// cover extremes, ties, restarts and clamped window sizes. Random phases then
// resize the window mid-stream under several idle and stall patterns, plus one
// long output hold-off that backs the block up.
// ----------------------------------------------------------------------------
module tb_sliding_window_maximum;
    import swm_pkg::*;

    localparam int WINDOW_DEPTH = 64;
    localparam int SAMPLE_BITS  = 16;
    localparam int BUS_W        = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int DRAIN_CYCLES = 400;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int PHASES       = 12;
    localparam int RESULT_DEPTH = 64;

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] value;
        logic [6:0]                    position;
    } candidate_t;

    logic             clk;
    logic             rst_n;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [BUS_W-1:0] s_axis_tdata;   // sample
    logic             s_axis_tuser;   // stream_start
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    logic [BUS_W-1:0] m_axis_tdata;   // window_max
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_data;

    candidate_t                    model_deque[WINDOW_DEPTH];
    int                            model_head  = 0;
    int                            model_count = 0;
    logic signed [SAMPLE_BITS-1:0] result_fifo[RESULT_DEPTH];
    int                            result_wr_idx = 0;
    int                            result_rd_idx = 0;
    logic [6:0]                    model_position;
    logic [6:0]                    model_warmup;
    logic [CFG_W-1:0]              model_window_reg;
    logic signed [SAMPLE_BITS-1:0] last_sample = '0;
    logic signed [SAMPLE_BITS-1:0] expected_max;

    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int hold_left          = 0;
    int cycle_count        = 0;
    int mismatches         = 0;
    int samples_sent       = 0;
    int maxima_checked     = 0;
    int window_writes      = 0;

    sliding_window_maximum #(
        .WINDOW_MAX   (WINDOW_DEPTH),
        .SAMPLE_WIDTH (SAMPLE_BITS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned effective_window(input logic [CFG_W-1:0] reg_value);
        if (reg_value == 0)
            return 1;
        if (reg_value > WINDOW_DEPTH)
            return WINDOW_DEPTH;
        return 32'(reg_value);
    endfunction

    function automatic int pending_results();
        return result_wr_idx - result_rd_idx;
    endfunction

    function void advance_max_model(input logic signed [SAMPLE_BITS-1:0] s,
                                    input logic start);
        int unsigned w;
        int          back;
        w = effective_window(model_window_reg);
        if (start)
        begin
            model_head     = 0;
            model_count    = 0;
            model_position = '0;
            model_warmup   = '0;
        end
        while (model_count > 0 &&
               7'(model_position - model_deque[model_head].position) >= w)
        begin
            model_head  = (model_head + 1) % WINDOW_DEPTH;
            model_count = model_count - 1;
        end
        while (model_count > 0 &&
               model_deque[(model_head + model_count - 1) % WINDOW_DEPTH].value < s)
            model_count = model_count - 1;
        if (model_count >= WINDOW_DEPTH)
        begin
            model_head  = (model_head + 1) % WINDOW_DEPTH;
            model_count = model_count - 1;
        end
        back                       = (model_head + model_count) % WINDOW_DEPTH;
        model_deque[back].value    = s;
        model_deque[back].position = model_position;
        model_count                = model_count + 1;
        model_position = model_position + 7'd1;
        if (model_warmup < WINDOW_DEPTH)
            model_warmup = model_warmup + 7'd1;
        if (model_warmup >= w)
        begin
            result_fifo[result_wr_idx % RESULT_DEPTH] = model_deque[model_head].value;
            result_wr_idx = result_wr_idx + 1;
        end
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
        int                            d;
        logic signed [SAMPLE_BITS-1:0] v;
        case ($urandom_range(9))
            0, 1, 2, 3: v = SAMPLE_BITS'($urandom);
            4, 5, 6:
            begin
                d = $urandom_range(4);
                v = SAMPLE_BITS'(d - 2);
            end
            7: v = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
            default:
            begin
                d = $urandom_range(64);
                v = SAMPLE_BITS'(int'(last_sample) + d - 32);
            end
        endcase
        last_sample = v;
        return v;
    endfunction

    // hold a random count of idle cycles, then offer one sample until it transfers
    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] value,
                               input logic start);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tuser  <= start;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        advance_max_model(value, start);
        samples_sent++;
        @(negedge clk);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_results() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_window(input logic [CFG_W-1:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        model_window_reg = value;
        window_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_idling(input int sender_pct, input int receiver_pct);
        sender_idle_pct    = sender_pct;
        receiver_stall_pct = receiver_pct;
    endtask

    task automatic test_reset_window();
        set_idling(0, 0);
        send_sample(16'sh7FFF, 1'b1);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh0000, 1'b0);
        send_sample(-16'sd1, 1'b0);
        send_sample(16'sd1, 1'b0);
    endtask

    task automatic test_ties_and_restart();
        write_window(7'd3);
        set_idling(21, 21);
        send_sample(16'sd5, 1'b1);
        send_sample(16'sd5, 1'b0);
        send_sample(16'sd5, 1'b0);
        send_sample(-16'sd3, 1'b0);
        send_sample(16'sd7, 1'b0);
        send_sample(16'sd7, 1'b0);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sd2, 1'b1);
        send_sample(16'sd1, 1'b0);
    endtask

    task automatic test_window_clamp();
        write_window(7'd0);
        set_idling(0, 69);
        send_sample(16'sd10, 1'b1);
        send_sample(-16'sd10, 1'b0);
        write_window(7'd127);
        set_idling(69, 0);
        repeat (4) send_sample(random_sample(), 1'b0);
    endtask

    // stall the output long enough that the input backs up, then pause the sender
    task automatic test_backpressure();
        int k;
        write_window(7'd2);
        set_idling(0, 0);
        hold_left = 400;
        send_sample(random_sample(), 1'b1);
        for (k = 0; k < 40; k++)
            send_sample(random_sample(), 1'b0);
        wait_idle();
        for (k = 0; k < 20; k++)
            send_sample(random_sample(), 1'b0);
    endtask

    task automatic test_random_phases();
        int          phase_window[PHASES] = '{64, 127, 2, 0, 100, 5, 1, 33, 17, 64, 9, 3};
        int          p;
        int          k;
        int          count;
        int unsigned w;
        for (p = 0; p < PHASES; p++)
        begin
            write_window(CFG_W'(phase_window[p]));
            case (p % 4)
                0: set_idling(0, 0);
                1: set_idling(69, 0);
                2: set_idling(0, 69);
                default: set_idling(21, 21);
            endcase
            w     = effective_window(CFG_W'(phase_window[p]));
            count = (w >= 32) ? 180 : 90;
            for (k = 0; k < count; k++)
                send_sample(random_sample(), $urandom_range(3 * w + 20) == 0);
        end
    endtask

    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results() == 0)
            begin
                $display("%0t: unexpected window_max transfer: expected none, got %0d",
                         $time, $signed(m_axis_tdata[SAMPLE_BITS-1:0]));
                mismatches++;
            end
            else
            begin
                expected_max  = result_fifo[result_rd_idx % RESULT_DEPTH];
                result_rd_idx = result_rd_idx + 1;
                if (m_axis_tdata[SAMPLE_BITS-1:0] !== expected_max)
                begin
                    $display("%0t: window_max mismatch: expected %0d, got %0d",
                             $time, expected_max, $signed(m_axis_tdata[SAMPLE_BITS-1:0]));
                    mismatches++;
                end
                maxima_checked++;
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, pending_results());
        $display("tb_sliding_window_maximum: done, errors");
        $finish;
    end

    initial
    begin
        rst_n            = 1'b0;
        s_axis_tvalid    = 1'b0;
        s_axis_tdata     = '0;
        s_axis_tuser     = 1'b0;
        cfg_valid        = 1'b0;
        cfg_data         = '0;
        model_position   = '0;
        model_warmup     = '0;
        model_window_reg = 7'd1;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_window();
        test_ties_and_restart();
        test_window_clamp();
        test_backpressure();
        test_random_phases();
        wait_idle();

        if (pending_results() != 0)
        begin
            $display("%0t: %0d expected window_max results never arrived",
                     $time, pending_results());
            mismatches++;
        end
        $display("sent %0d samples, checked %0d window maxima, %0d window writes",
                 samples_sent, maxima_checked, window_writes);
        $display("covered ties, restarts, clamped and resized windows, output back-pressure");
        if (mismatches == 0)
            $display("tb_sliding_window_maximum: done, clean");
        else
            $display("tb_sliding_window_maximum: done, errors");
        $finish;
    end

endmodule
